### src/cac_pkg.sv
`timescale 1ns / 1ps
package cac_pkg;

  localparam int TempW = 13;
  localparam int HumW  = 10;
  localparam int LuxW  = 16;
  localparam int SoilW = 7;
  localparam int LvlW  = 7;
  localparam int DivW  = 34;

  typedef enum logic [1:0] {
    ACT_FAN  = 2'd0,
    ACT_HUM  = 2'd1,
    ACT_LED  = 2'd2,
    ACT_PUMP = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    CFG_TEMP_LOW  = 3'd0,
    CFG_TEMP_HIGH = 3'd1,
    CFG_HUM_ON    = 3'd2,
    CFG_HUM_OFF   = 3'd3,
    CFG_LUX_LOW   = 3'd4,
    CFG_LUX_HIGH  = 3'd5,
    CFG_SOIL_ON   = 3'd6,
    CFG_SOIL_OFF  = 3'd7
  } cfg_idx_t;

  // Datapath operation codes issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LOAD    = 4'd1,
    OP_DIV_E   = 4'd2,
    OP_DIV_EC  = 4'd3,
    OP_DIV_FZ  = 4'd4,
    OP_DIV_LED = 4'd5,
    OP_MU      = 4'd6,
    OP_ACC     = 4'd7,
    OP_FAN     = 4'd8,
    OP_EMIT    = 4'd9
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       div_start;
    logic [4:0] rule;
    act_t       act;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic [3:0] pend;
  } sts_t;

  // Rule base: output set for error row i, change column j.
  function automatic logic [2:0] rule_set(input logic [4:0] k);
    logic [2:0] r;
    case (k)
      5'd0, 5'd1, 5'd2, 5'd5:                          r = 3'd0;
      5'd3, 5'd4, 5'd6, 5'd7, 5'd10, 5'd11:            r = 3'd1;
      5'd8, 5'd9, 5'd12, 5'd15, 5'd16:                 r = 3'd2;
      5'd13, 5'd17:                                    r = 3'd3;
      default:                                         r = 3'd4;
    endcase
    return r;
  endfunction

  // Three times the center of each output set.
  function automatic logic [8:0] centre3(input logic [2:0] s);
    logic [8:0] c;
    case (s)
      3'd0:    c = 9'd10;
      3'd1:    c = 9'd105;
      3'd2:    c = 9'd45;
      3'd3:    c = 9'd195;
      default: c = 9'd260;
    endcase
    return c;
  endfunction

endpackage

### src/cac_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module cac_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [cac_pkg::DivW-1:0] num,
  input  logic [cac_pkg::DivW-1:0] den,
  output logic                    done,
  output logic [cac_pkg::DivW-1:0] quo
);
  import cac_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] q_r, q_nxt, rem_r, rem_nxt, d_r, d_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [DivW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      d_nxt    = den;
      cnt_nxt  = CntW'(DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, q_r[DivW-1]} - {1'b0, d_r};
      if (!trial[DivW]) begin
        rem_nxt = trial[DivW-1:0];
        q_nxt   = {q_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DivW-2:0], q_r[DivW-1]};
        q_nxt   = {q_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

### src/cac_datapath.sv
`timescale 1ns / 1ps
module cac_datapath #(
  parameter int LEVEL_DEADBAND = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cac_pkg::cmd_t            cmd,
  output cac_pkg::sts_t            sts,
  output logic                     lux_ramp,
  input  logic                     cfg_valid,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic signed [13:0]       in_air_temp,
  input  logic [9:0]               in_air_humidity,
  input  logic [15:0]              in_light_level,
  input  logic [6:0]               in_soil_moisture,
  output logic [1:0]               out_actuator,
  output logic                     out_switch_on,
  output logic [6:0]               out_level,
  output logic                     out_last_of_run
);
  import cac_pkg::*;

  localparam logic signed [17:0] QONE = 18'sd16384;
  localparam logic [7:0] DBAND = 8'(LEVEL_DEADBAND);

  // Configuration registers.
  logic [12:0] tlo_r, thi_r;
  logic [9:0]  hon_r, hoff_r;
  logic [15:0] llo_r, lhi_r;
  logic [6:0]  son_r, soff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlo_r <= 13'd2000; thi_r <= 13'd2800;
      hon_r <= 10'd800;  hoff_r <= 10'd900;
      llo_r <= 16'd200;  lhi_r <= 16'd400;
      son_r <= 7'd40;    soff_r <= 7'd60;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP_LOW:  tlo_r  <= cfg_data[12:0];
        CFG_TEMP_HIGH: thi_r  <= cfg_data[12:0];
        CFG_HUM_ON:    hon_r  <= cfg_data[9:0];
        CFG_HUM_OFF:   hoff_r <= cfg_data[9:0];
        CFG_LUX_LOW:   llo_r  <= cfg_data;
        CFG_LUX_HIGH:  lhi_r  <= cfg_data;
        CFG_SOIL_ON:   son_r  <= cfg_data[6:0];
        default:       soff_r <= cfg_data[6:0];
      endcase
    end
  end

  // Sample registers and persistent actuator state.
  logic signed [15:0] e2_r, prev_r;
  logic signed [16:0] ec2_r;
  logic               first_r;
  logic [13:0]        emax_r;
  logic [9:0]         hum_r;
  logic [15:0]        lux_r;
  logic [6:0]         soil_r;
  logic signed [17:0] en_r, ecn_r;
  logic [15:0]        me_r [5];
  logic [15:0]        mc_r [5];
  logic [33:0]        num_r;
  logic [20:0]        den_r;
  logic [6:0]         speed_r, led_r;
  logic signed [8:0]  fan_sent_r, led_sent_r;
  logic               fan_on_r, hum_on_r, led_on_r, pump_on_r;
  logic               hum_new_r, pump_new_r;
  logic [3:0]         pend_r;

  logic signed [15:0] e2_w;
  logic signed [16:0] ec2_w;
  logic signed [14:0] emax_w;
  logic [DivW-1:0]    dnum, dden, dquo;
  logic               ddone;

  assign e2_w   = 16'($signed({in_air_temp, 1'b0})) - 16'($signed({3'b0, {1'b0, tlo_r} + {1'b0, thi_r}}));
  assign ec2_w  = first_r ? 17'sd0 : 17'(e2_w) - 17'(prev_r);
  assign emax_w = $signed({2'b0, thi_r}) - $signed({2'b0, tlo_r});

  // The LED level needs the ramp division only between the two light limits.
  assign lux_ramp = (in_light_level >= llo_r) && (in_light_level < lhi_r);

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  // Divider operand selection.
  always_comb begin
    dnum = '0;
    dden = 34'd1;
    case (cmd.op)
      OP_DIV_E: begin
        dnum = DivW'({abs16(e2_r), 14'b0});
        dden = DivW'({emax_r, 1'b0});
      end
      OP_DIV_EC: begin
        dnum = DivW'(({abs17(ec2_r), 14'b0}) * 34'd10);
        dden = DivW'(emax_r * 17'd6);
      end
      OP_DIV_FZ: begin
        dnum = num_r;
        dden = DivW'(den_r * 23'd3);
      end
      OP_DIV_LED: begin
        dnum = DivW'((lhi_r - lux_r) * 23'd100);
        dden = DivW'(lhi_r - llo_r);
      end
      default: ;
    endcase
  end

  cac_div u_div (
    .clk, .rst_n, .start(cmd.div_start), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  function automatic logic [15:0] tri_mu(input logic signed [17:0] x, input logic signed [17:0] a);
    logic signed [17:0] d;
    d = x - a;
    if (d <= 0 || d >= 18'sd16384) return 16'd0;
    if (d <= 18'sd8192) return 16'(d * 4);
    return 16'((18'sd16384 - d) * 4);
  endfunction

  // Memberships in Q1.15; full membership of the two outer sets is held as 16'hFFFF.
  function automatic logic [15:0] mu_at(input logic signed [17:0] x, input int k);
    logic [15:0] m;
    case (k)
      0:       m = (x <= -QONE) ? 16'hFFFF : (x >= -18'sd8192) ? 16'd0 : 16'((-18'sd8192 - x) * 4);
      1:       m = tri_mu(x, -QONE);
      2:       m = tri_mu(x, -18'sd8192);
      3:       m = tri_mu(x, 18'sd0);
      default: m = (x >= QONE) ? 16'hFFFF : (x <= 18'sd8192) ? 16'd0 : 16'((x - 18'sd8192) * 4);
    endcase
    return m;
  endfunction

  // Split the rule number into error row and change column.
  logic [2:0] ri, rj;
  assign ri = (cmd.rule >= 5'd20) ? 3'd4 : (cmd.rule >= 5'd15) ? 3'd3 :
              (cmd.rule >= 5'd10) ? 3'd2 : (cmd.rule >= 5'd5) ? 3'd1 : 3'd0;
  assign rj = 3'(cmd.rule - {ri, 2'b0} - {2'b0, ri});

  // Saturated mu value 0xFFFF stands for 32768.
  logic [15:0] mi, mj, mmin;
  logic [16:0] mval;
  assign mi   = me_r[ri];
  assign mj   = mc_r[rj];
  assign mmin = (mi < mj) ? mi : mj;
  assign mval = (mmin == 16'hFFFF) ? 17'd32768 : {1'b0, mmin};

  logic [6:0] fan_w;
  logic       fan_send, led_send;
  logic [8:0] fdiff, ldiff;
  assign fan_w   = (den_r == '0 || dquo > 34'd100) ? (den_r == '0 ? 7'd0 : 7'd100) : dquo[6:0];
  assign fdiff   = ($signed({2'b0, speed_r}) > fan_sent_r) ? 9'($signed({2'b0, speed_r}) - fan_sent_r)
                                                          : 9'(fan_sent_r - $signed({2'b0, speed_r}));
  assign ldiff   = ($signed({2'b0, led_r}) > led_sent_r) ? 9'($signed({2'b0, led_r}) - led_sent_r)
                                                        : 9'(led_sent_r - $signed({2'b0, led_r}));
  assign fan_send = ((speed_r != 0) != fan_on_r) || (fdiff > {1'b0, DBAND});
  assign led_send = ((led_r != 0) != led_on_r) || (ldiff > {1'b0, DBAND});

  logic sat_q;
  assign sat_q = dquo > 34'd16384;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      first_r    <= 1'b1;
      fan_sent_r <= -9'sd1;
      led_sent_r <= -9'sd1;
      fan_on_r   <= 1'b0;
      hum_on_r   <= 1'b0;
      led_on_r   <= 1'b0;
      pump_on_r  <= 1'b0;
      pend_r     <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          e2_r    <= e2_w;
          ec2_r   <= ec2_w;
          prev_r  <= e2_w;
          first_r <= 1'b0;
          emax_r  <= (emax_w < 15'sd50) ? 14'd50 : emax_w[13:0];
          hum_r   <= in_air_humidity;
          lux_r   <= in_light_level;
          soil_r  <= in_soil_moisture;
          num_r   <= '0;
          den_r   <= '0;
          led_r   <= (in_light_level < llo_r) ? 7'd100 : 7'd0;
        end
        OP_DIV_E:
          if (ddone) en_r <= e2_r[15] ? -(sat_q ? QONE : $signed({1'b0, dquo[16:0]}))
                                      : (sat_q ? QONE : $signed({1'b0, dquo[16:0]}));
        OP_DIV_EC:
          if (ddone) ecn_r <= ec2_r[16] ? -(sat_q ? QONE : $signed({1'b0, dquo[16:0]}))
                                        : (sat_q ? QONE : $signed({1'b0, dquo[16:0]}));
        OP_DIV_LED:
          if (ddone) led_r <= dquo[6:0];
        OP_MU: begin
          for (int k = 0; k < 5; k++) begin
            me_r[k] <= mu_at(en_r, k);
            mc_r[k] <= mu_at(ecn_r, k);
          end
        end
        OP_ACC: begin
          num_r <= num_r + 34'(mval) * 34'(centre3(rule_set(cmd.rule)));
          den_r <= den_r + 21'(mval);
        end
        OP_DIV_FZ:
          if (ddone) speed_r <= (fan_w < 7'd30) ? 7'd0 : fan_w;
        OP_FAN: begin
          hum_new_r  <= (hum_r < hon_r) ? 1'b1 : (hum_r > hoff_r) ? 1'b0 : hum_on_r;
          pump_new_r <= (soil_r < son_r) ? 1'b1 : (soil_r > soff_r) ? 1'b0 : pump_on_r;
          pend_r     <= {((soil_r < son_r) ? 1'b1 : (soil_r > soff_r) ? 1'b0 : pump_on_r) != pump_on_r,
                         led_send,
                         ((hum_r < hon_r) ? 1'b1 : (hum_r > hoff_r) ? 1'b0 : hum_on_r) != hum_on_r,
                         fan_send};
        end
        OP_EMIT: begin
          out_actuator    <= cmd.act;
          out_last_of_run <= cmd.last;
          pend_r[cmd.act] <= 1'b0;
          case (cmd.act)
            ACT_FAN: begin
              out_switch_on <= speed_r != 0; out_level <= speed_r;
              fan_on_r <= speed_r != 0; fan_sent_r <= $signed({2'b0, speed_r});
            end
            ACT_HUM: begin
              out_switch_on <= hum_new_r; out_level <= '0; hum_on_r <= hum_new_r;
            end
            ACT_LED: begin
              out_switch_on <= led_r != 0; out_level <= led_r;
              led_on_r <= led_r != 0; led_sent_r <= $signed({2'b0, led_r});
            end
            default: begin
              out_switch_on <= pump_new_r; out_level <= '0; pump_on_r <= pump_new_r;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign sts.div_done = ddone;
  assign sts.pend     = pend_r;

endmodule

### src/cac_ctrl.sv
`timescale 1ns / 1ps
module cac_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          lux_ramp,
  output cac_pkg::cmd_t cmd,
  input  cac_pkg::sts_t sts
);
  import cac_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DE    = 10'b0000000010,
    S_DEC   = 10'b0000000100,
    S_MU    = 10'b0000001000,
    S_ACC   = 10'b0000010000,
    S_DFZ   = 10'b0000100000,
    S_DLED  = 10'b0001000000,
    S_FAN   = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t     st_r, st_nxt;
  logic       go_r, go_nxt;
  logic [4:0] rule_r, rule_nxt;
  logic       ov_r, ov_nxt;
  logic       ramp_r, ramp_nxt;
  act_t       sel;
  logic [3:0] rest;

  // Lowest pending actuator goes first.
  always_comb begin
    sel = ACT_PUMP;
    if (sts.pend[0]) sel = ACT_FAN;
    else if (sts.pend[1]) sel = ACT_HUM;
    else if (sts.pend[2]) sel = ACT_LED;
    rest = sts.pend & ~(4'b1 << sel);
  end

  // The output register holds a waiting word while the next sensor word is taken.
  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    st_nxt   = st_r;
    go_nxt   = 1'b0;
    rule_nxt = rule_r;
    ov_nxt   = ov_r && out_stall;
    ramp_nxt = ramp_r;
    cmd      = '{op: OP_NONE, div_start: 1'b0, rule: rule_r, act: sel, last: rest == '0};
    unique case (st_r)
      S_IDLE:
        if (in_valid) begin
          cmd.op   = OP_LOAD;
          ramp_nxt = lux_ramp;
          st_nxt   = S_DE;
          go_nxt   = 1'b1;
        end
      S_DE: begin
        cmd.op = OP_DIV_E; cmd.div_start = go_r;
        if (sts.div_done) begin st_nxt = S_DEC; go_nxt = 1'b1; end
      end
      S_DEC: begin
        cmd.op = OP_DIV_EC; cmd.div_start = go_r;
        if (sts.div_done) st_nxt = S_MU;
      end
      S_MU: begin
        cmd.op = OP_MU; rule_nxt = '0; st_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC; rule_nxt = rule_r + 1'b1;
        if (rule_r == 5'd24) begin st_nxt = S_DFZ; go_nxt = 1'b1; end
      end
      S_DFZ: begin
        cmd.op = OP_DIV_FZ; cmd.div_start = go_r;
        if (sts.div_done) begin
          st_nxt = ramp_r ? S_DLED : S_FAN; go_nxt = 1'b1;
        end
      end
      S_DLED: begin
        cmd.op = OP_DIV_LED; cmd.div_start = go_r;
        if (sts.div_done) st_nxt = S_FAN;
      end
      S_FAN: begin
        cmd.op = OP_FAN; st_nxt = S_EMIT;
      end
      S_EMIT:
        if (sts.pend == '0) st_nxt = S_IDLE;
        else if (!ov_r || !out_stall) begin
          cmd.op = OP_EMIT; ov_nxt = 1'b1; st_nxt = S_OUT;
        end
      default: st_nxt = S_EMIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      go_r   <= 1'b0;
      ov_r   <= 1'b0;
      rule_r <= '0;
      ramp_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      go_r   <= go_nxt;
      ov_r   <= ov_nxt;
      rule_r <= rule_nxt;
      ramp_r <= ramp_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_rule_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ACC) |-> (rule_r <= 5'd24)) else $error("rule index out of range");
  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |=> out_valid) else $error("emitted word not shown");
`endif

endmodule

### src/climate_actuator_control.sv
`timescale 1ns / 1ps
// Climate actuator control. Each sensor word produces zero to four actuator command
// words in the order fan, humidifier, LED, pump; last_of_run marks the final one. The
// fan level comes from a 5x5 fuzzy PD controller evaluated by one shared 34-bit
// restoring divider and a single accumulate step per rule. After a sensor word is taken
// the input stalls while the block works through three divisions, the accumulate steps
// of the 25 rules, the memberships, the send decisions and the first command check. A
// fourth division runs when the light level lies between the two light limits. Each
// command word then passes through an emit state and an output state; the emit state
// waits while a word held at the output is stalled. Once no word is pending, the block
// returns to idle, where it can take the next sensor word. A command word still waiting
// at the output does not hold off the next sensor word. Configuration writes are taken
// at any time and must only occur while idle.
module climate_actuator_control #(
  parameter int LEVEL_DEADBAND = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [13:0] in_air_temp,
  input  logic [9:0]        in_air_humidity,
  input  logic [15:0]       in_light_level,
  input  logic [6:0]        in_soil_moisture,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_actuator,
  output logic              out_switch_on,
  output logic [6:0]        out_level,
  output logic              out_last_of_run,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import cac_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic lux_ramp;

  assign cfg_ready = 1'b1;

  cac_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .lux_ramp, .cmd, .sts
  );

  cac_datapath #(.LEVEL_DEADBAND(LEVEL_DEADBAND)) u_dp (
    .clk, .rst_n, .cmd, .sts, .lux_ramp, .cfg_valid, .cfg_index, .cfg_data,
    .in_air_temp, .in_air_humidity, .in_light_level, .in_soil_moisture,
    .out_actuator, .out_switch_on, .out_level, .out_last_of_run
  );

endmodule
